/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file; clk and arst_n are taken from the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CLPA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clpa check failed");

// next-cycle implication
`define CLPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clpa check failed");

`endif

/* hw/rtl/clpa_pkg.sv */
// Types and constants for the closed-path area core
`default_nettype none

package clpa_pkg;

	localparam int COORD_BITS = 16;
	localparam int ACC_BITS   = 48;
	localparam int TERM_W     = COORD_BITS + 1;
	localparam int PAIR_W     = COORD_BITS + 2;
	localparam int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_W      = ((ACC_BITS + 7) / 8) * 8;
	localparam int STATUS_W   = 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [TERM_W-1:0]     term_t;
	typedef logic signed [PAIR_W-1:0]     pair_t;
	typedef logic signed [ACC_BITS-1:0]   acc_t;

	localparam term_t TERM_ONE  = term_t'(1);
	localparam term_t TERM_MONE = term_t'(-1);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_NOT4   = 2'd1,
		ST_OPEN   = 2'd2
	} status_t;

	// result of checking one step between two points
	typedef struct packed {
		logic  ok;
		term_t term;
	} step_res_t;

endpackage

`default_nettype wire

/* hw/rtl/closed_path_area_4connected_core.sv */
// From an accepted input word to its result word on the master side: input register, then output register.
// Throughput: one point per cycle; the input register only holds when a closing
// point meets an output word that has not yet been taken.
// Path state (first point, previous point, sum, fault) updates once per point.
// arst_n clears the valid flags, the fault flag and the sum, and arms the
// start-of-path flag; no clearing pass is needed.
`default_nettype none

module closed_path_area_4connected_core (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [clpa_pkg::IN_W-1:0]            s_tdata,  // pos_x, pos_y
	input  wire                                  s_tlast,  // is_last
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [clpa_pkg::OUT_W-1:0]           m_tdata,  // area_twice
	output logic [clpa_pkg::STATUS_W-1:0]        m_tuser   // status
);

	// input register
	logic             valid_s1;
	logic             last_s1;
	clpa_pkg::coord_t x_s1;
	clpa_pkg::coord_t y_s1;
	logic             go_s1;

	// path state
	clpa_pkg::coord_t start_x_q;
	clpa_pkg::coord_t start_y_q;
	clpa_pkg::coord_t prev_x_q;
	clpa_pkg::coord_t prev_y_q;
	clpa_pkg::acc_t   area_q;
	logic             fault_q;
	logic             first_q;

	// output register
	logic               out_valid_q;
	clpa_pkg::acc_t     out_area_q;
	clpa_pkg::status_t  out_status_q;

	clpa_pkg::step_res_t step_r;
	clpa_pkg::step_res_t close_r;
	logic                take_step;
	logic                fault_n;
	clpa_pkg::coord_t    p2_x;
	clpa_pkg::coord_t    p2_y;
	clpa_pkg::coord_t    st_x;
	clpa_pkg::coord_t    st_y;
	clpa_pkg::term_t     t1;
	clpa_pkg::pair_t     t_both;
	clpa_pkg::acc_t      base;
	clpa_pkg::acc_t      sum1;
	clpa_pkg::acc_t      sum_close;
	clpa_pkg::status_t   status_n;

	assign go_s1    = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x_s1    <= clpa_pkg::coord_t'(s_tdata[clpa_pkg::COORD_BITS-1:0]);
			y_s1    <= clpa_pkg::coord_t'(s_tdata[2*clpa_pkg::COORD_BITS-1:clpa_pkg::COORD_BITS]);
			last_s1 <= s_tlast;
		end
	end

	// step from the previous point to this one
	clpa_step u_step (
		.from_x (prev_x_q),
		.from_y (prev_y_q),
		.to_x   (x_s1),
		.to_y   (y_s1),
		.res    (step_r)
	);

	assign take_step = !first_q && !fault_q && step_r.ok;
	assign fault_n   = !first_q && (fault_q || !step_r.ok);
	assign p2_x      = (first_q || take_step) ? x_s1 : prev_x_q;
	assign p2_y      = (first_q || take_step) ? y_s1 : prev_y_q;
	assign st_x      = first_q ? x_s1 : start_x_q;
	assign st_y      = first_q ? y_s1 : start_y_q;

	// closing step back to the first point; zero term when already there
	clpa_step u_close (
		.from_x (p2_x),
		.from_y (p2_y),
		.to_x   (st_x),
		.to_y   (st_y),
		.res    (close_r)
	);

	assign t1        = take_step ? step_r.term : '0;
	assign t_both    = clpa_pkg::pair_t'(t1) + clpa_pkg::pair_t'(close_r.term);
	assign base      = first_q ? '0 : area_q;
	assign sum1      = base + clpa_pkg::acc_t'(t1);
	assign sum_close = base + clpa_pkg::acc_t'(t_both);

	always_comb begin
		if (fault_n) begin
			status_n = clpa_pkg::ST_NOT4;
		end else if (!close_r.ok) begin
			status_n = clpa_pkg::ST_OPEN;
		end else begin
			status_n = clpa_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			fault_q <= 1'b0;
			area_q  <= '0;
		end else if (go_s1) begin
			first_q <= last_s1;
			fault_q <= fault_n;
			area_q  <= sum1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
		end else if (go_s1) begin
			start_x_q <= st_x;
			start_y_q <= st_y;
			prev_x_q  <= p2_x;
			prev_y_q  <= p2_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			out_area_q   <= (status_n == clpa_pkg::ST_OK) ? sum_close : '0;
			out_status_q <= status_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = clpa_pkg::OUT_W'($unsigned(out_area_q));
	assign m_tuser  = out_status_q;

endmodule

`default_nettype wire

/* hw/rtl/clpa_step.sv */
// Unit-step check and twice-area term for a step between two points
`default_nettype none

module clpa_step (
	input  clpa_pkg::coord_t    from_x,
	input  clpa_pkg::coord_t    from_y,
	input  clpa_pkg::coord_t    to_x,
	input  clpa_pkg::coord_t    to_y,
	output clpa_pkg::step_res_t res
);

	clpa_pkg::term_t dx;
	clpa_pkg::term_t dy;
	clpa_pkg::term_t fx;
	clpa_pkg::term_t fy;
	logic            dx_zero;
	logic            dy_zero;
	logic            dx_unit;
	logic            dy_unit;

	assign fx = clpa_pkg::term_t'(from_x);
	assign fy = clpa_pkg::term_t'(from_y);
	assign dx = clpa_pkg::term_t'(to_x) - fx;
	assign dy = clpa_pkg::term_t'(to_y) - fy;

	assign dx_zero = (dx == '0);
	assign dy_zero = (dy == '0);
	assign dx_unit = (dx == clpa_pkg::TERM_ONE) || (dx == clpa_pkg::TERM_MONE);
	assign dy_unit = (dy == clpa_pkg::TERM_ONE) || (dy == clpa_pkg::TERM_MONE);

	always_comb begin
		res.ok = (dx_zero && (dy_zero || dy_unit)) || (dy_zero && dx_unit);
		if (dx == clpa_pkg::TERM_ONE) begin
			res.term = -fy;
		end else if (dx == clpa_pkg::TERM_MONE) begin
			res.term = fy;
		end else if (dy == clpa_pkg::TERM_ONE) begin
			res.term = fx;
		end else if (dy == clpa_pkg::TERM_MONE) begin
			res.term = -fx;
		end else begin
			res.term = '0;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/clpa_checker.sv */
// Port-level checks for the closed-path area core, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module clpa_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               s_tvalid,
	input wire                               s_tready,
	input wire                               s_tlast,
	input wire                               m_tvalid,
	input wire                               m_tready,
	input wire [clpa_pkg::OUT_W-1:0]         m_tdata,
	input wire [clpa_pkg::STATUS_W-1:0]      m_tuser
);

	logic close_word;
	logic out_bad_status;
	logic status_known;

	assign close_word     = s_tvalid && s_tready && s_tlast;
	assign out_bad_status = (m_tuser != clpa_pkg::ST_OK);
	assign status_known   = (m_tuser == clpa_pkg::ST_OK) || (m_tuser == clpa_pkg::ST_NOT4)
		|| (m_tuser == clpa_pkg::ST_OPEN);

	// a held word stays and keeps its contents
	`CLPA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`CLPA_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
	// any error word reports a zero area
	`CLPA_ASSERT_NOW(a_err_zero, m_tvalid && out_bad_status, m_tdata == '0)
	// only the three defined status codes appear
	`CLPA_ASSERT_NOW(a_status_code, m_tvalid, status_known)
	// a fresh result needs a closing word accepted earlier on the input side
	`CLPA_ASSERT_NOW(a_no_early_out, $rose(m_tvalid), $past(close_word, 2))

endmodule

bind closed_path_area_4connected_core clpa_checker u_clpa_checker (.*);

`default_nettype wire
